FILE: design/vwcc_pkg.sv
// Shared types and constants for the vehicle warning chime controller.
// Used by vwcc_cfg_regs, vwcc_tick_logic and the top level; no dependencies.
package vwcc_pkg;

  localparam int SEAT_COUNT_DEF = 8;
  localparam int SEAT_W         = 8;
  localparam int SPEED_W        = 16;
  localparam int LIMIT_W        = 15;
  localparam int COUNT_W        = 8;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 15;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DOOR_SPEED_LIMIT   = 3'd0,
    REG_BRAKE_SPEED_LIMIT  = 3'd1,
    REG_BELT_SPEED_LIMIT   = 3'd2,
    REG_BLINK_ON_LIMIT     = 3'd3,
    REG_BLINK_WRAP         = 3'd4,
    REG_REMOTE_ALARM_TICKS = 3'd5
  } cfg_idx_t;

  localparam logic [LIMIT_W-1:0] DOOR_SPEED_LIMIT_RST   = 15'd100;
  localparam logic [LIMIT_W-1:0] BRAKE_SPEED_LIMIT_RST  = 15'd300;
  localparam logic [LIMIT_W-1:0] BELT_SPEED_LIMIT_RST   = 15'd300;
  localparam logic [COUNT_W-1:0] BLINK_ON_LIMIT_RST     = 8'd33;
  localparam logic [COUNT_W-1:0] BLINK_WRAP_RST         = 8'd66;
  localparam logic [COUNT_W-1:0] REMOTE_ALARM_TICKS_RST = 8'd16;

  typedef struct packed {
    logic [LIMIT_W-1:0] door_speed_limit;
    logic [LIMIT_W-1:0] brake_speed_limit;
    logic [LIMIT_W-1:0] belt_speed_limit;
    logic [COUNT_W-1:0] blink_on_limit;
    logic [COUNT_W-1:0] blink_wrap;
    logic [COUNT_W-1:0] remote_alarm_ticks;
  } cfg_t;

  typedef struct packed {
    logic                ignition_on;
    logic                door_ajar;
    logic                park_brake_on;
    logic signed [SPEED_W-1:0] vehicle_speed;
    logic [SEAT_W-1:0]   seat_occupied;
    logic [SEAT_W-1:0]   belt_flags;
    logic                remote_alarm_request;
  } tick_in_t;

  typedef struct packed {
    logic                door_warn;
    logic                brake_warn;
    logic [SEAT_W-1:0]   seat_warn;
    logic                belt_warn;
    logic [COUNT_W-1:0]  blink_count;
    logic                remote_active;
    logic [COUNT_W-1:0]  remote_count;
    logic                buzzer_level;
  } chime_state_t;

  localparam chime_state_t CHIME_STATE_RST = '0;

endpackage

FILE: design/vwcc_cfg_regs.sv
// Configuration register file of the chime controller: limits and blink timing.
// Depends on vwcc_pkg.
module vwcc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [vwcc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [vwcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                             cfg_ready,
  output vwcc_pkg::cfg_t                   cfg
);

  vwcc_pkg::cfg_t cfg_r;

  // Writes are always taken; indexes past the list are dropped.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.door_speed_limit   <= vwcc_pkg::DOOR_SPEED_LIMIT_RST;
      cfg_r.brake_speed_limit  <= vwcc_pkg::BRAKE_SPEED_LIMIT_RST;
      cfg_r.belt_speed_limit   <= vwcc_pkg::BELT_SPEED_LIMIT_RST;
      cfg_r.blink_on_limit     <= vwcc_pkg::BLINK_ON_LIMIT_RST;
      cfg_r.blink_wrap         <= vwcc_pkg::BLINK_WRAP_RST;
      cfg_r.remote_alarm_ticks <= vwcc_pkg::REMOTE_ALARM_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        vwcc_pkg::REG_DOOR_SPEED_LIMIT:   cfg_r.door_speed_limit   <= cfg_wdata;
        vwcc_pkg::REG_BRAKE_SPEED_LIMIT:  cfg_r.brake_speed_limit  <= cfg_wdata;
        vwcc_pkg::REG_BELT_SPEED_LIMIT:   cfg_r.belt_speed_limit   <= cfg_wdata;
        vwcc_pkg::REG_BLINK_ON_LIMIT:     cfg_r.blink_on_limit     <= cfg_wdata[7:0];
        vwcc_pkg::REG_BLINK_WRAP:         cfg_r.blink_wrap         <= cfg_wdata[7:0];
        vwcc_pkg::REG_REMOTE_ALARM_TICKS: cfg_r.remote_alarm_ticks <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/vwcc_tick_logic.sv
// Next-state logic for one control tick: warnings first, then the buzzer.
// Purely combinational; depends on vwcc_pkg.
module vwcc_tick_logic #(
  parameter int SEAT_COUNT = vwcc_pkg::SEAT_COUNT_DEF
) (
  input  vwcc_pkg::cfg_t         cfg,
  input  vwcc_pkg::tick_in_t     tick,
  input  vwcc_pkg::chime_state_t cur,
  output vwcc_pkg::chime_state_t nxt
);

  localparam logic [vwcc_pkg::SEAT_W-1:0] SEAT_MASK =
    vwcc_pkg::SEAT_W'((9'd1 << SEAT_COUNT) - 9'd1);

  logic signed [vwcc_pkg::SPEED_W:0] speed_x;
  logic signed [vwcc_pkg::SPEED_W:0] door_lim_x;
  logic signed [vwcc_pkg::SPEED_W:0] door_lim_neg;
  logic signed [vwcc_pkg::SPEED_W:0] brake_lim_x;
  logic signed [vwcc_pkg::SPEED_W:0] belt_lim_x;
  logic                              door_fast;
  logic                              brake_fast;
  logic                              belt_fast;
  logic [vwcc_pkg::COUNT_W-1:0]      blink_inc;
  logic [vwcc_pkg::COUNT_W-1:0]      remote_inc;
  logic                              blink_buzzer;
  logic [vwcc_pkg::COUNT_W-1:0]      blink_next;

  // All speed compares are done in 17-bit signed so negated limits fit.
  assign speed_x      = {tick.vehicle_speed[vwcc_pkg::SPEED_W-1], tick.vehicle_speed};
  assign door_lim_x   = {2'b00, cfg.door_speed_limit};
  assign door_lim_neg = -door_lim_x;
  assign brake_lim_x  = {2'b00, cfg.brake_speed_limit};
  assign belt_lim_x   = {2'b00, cfg.belt_speed_limit};
  assign door_fast    = (speed_x >= door_lim_x) || (speed_x <= door_lim_neg);
  assign brake_fast   = speed_x >= brake_lim_x;
  assign belt_fast    = speed_x > belt_lim_x;

  assign blink_inc  = cur.blink_count + 8'd1;
  assign remote_inc = cur.remote_count + 8'd1;

  // Blink phase: on below the on limit, off up to the wrap point, and past
  // the wrap point the buzzer keeps whatever level it had.
  always_comb begin
    blink_buzzer = cur.buzzer_level;
    blink_next   = blink_inc;
    if (blink_inc < cfg.blink_on_limit) begin
      blink_buzzer = 1'b1;
    end else if (blink_inc <= cfg.blink_wrap) begin
      blink_buzzer = 1'b0;
      if (blink_inc == cfg.blink_wrap) begin
        blink_next = '0;
      end
    end
  end

  always_comb begin
    nxt = cur;
    if (tick.ignition_on) begin
      nxt.door_warn  = tick.door_ajar && door_fast;
      nxt.brake_warn = tick.park_brake_on && brake_fast;
      nxt.seat_warn  = tick.seat_occupied & tick.belt_flags & SEAT_MASK;
      nxt.belt_warn  = |(tick.seat_occupied & tick.belt_flags & SEAT_MASK);
    end else begin
      nxt.door_warn  = 1'b0;
      nxt.brake_warn = 1'b0;
    end

    // A remote request latches even while a warning owns the buzzer.
    nxt.remote_active = cur.remote_active | tick.remote_alarm_request;

    if (nxt.door_warn || nxt.brake_warn) begin
      nxt.buzzer_level = blink_buzzer;
      nxt.blink_count  = blink_next;
    end else if (nxt.belt_warn) begin
      if (belt_fast) begin
        nxt.buzzer_level = blink_buzzer;
        nxt.blink_count  = blink_next;
      end else begin
        nxt.buzzer_level = 1'b0;
      end
    end else if (nxt.remote_active) begin
      if (remote_inc > cfg.remote_alarm_ticks) begin
        nxt.buzzer_level  = 1'b0;
        nxt.remote_active = 1'b0;
        nxt.remote_count  = '0;
      end else begin
        nxt.buzzer_level  = 1'b1;
        nxt.remote_count  = remote_inc;
      end
    end else begin
      nxt.buzzer_level = 1'b0;
      nxt.blink_count  = '0;
    end
  end

endmodule

FILE: design/vehicle_warning_chime_controller_unit.sv
// Vehicle warning chime controller. Each input transfer is one control tick
// and yields exactly one result transfer. The block is a two-stage pipeline:
// an input register, then the tick logic that updates the warning, blink and
// remote-alarm state and loads the result register. It takes one item per
// cycle while the result channel does not stall; a stalled result stops the
// tick logic and, once the input register is full, stalls the input.
// Configuration writes are always ready and must be issued while no item is
// in flight.
// Depends on vwcc_pkg, vwcc_cfg_regs and vwcc_tick_logic.
module vehicle_warning_chime_controller_unit #(
  parameter int SEAT_COUNT = vwcc_pkg::SEAT_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_ignition_on,
  input  logic                                   in_door_ajar,
  input  logic                                   in_park_brake_on,
  input  logic signed [vwcc_pkg::SPEED_W-1:0]    in_vehicle_speed,
  input  logic [vwcc_pkg::SEAT_W-1:0]            in_seat_occupied,
  input  logic [vwcc_pkg::SEAT_W-1:0]            in_belt_flags,
  input  logic                                   in_remote_alarm_request,
  // Result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_buzzer_on,
  output logic                                   out_door_warning,
  output logic                                   out_brake_warning,
  output logic                                   out_belt_warning,
  output logic [vwcc_pkg::SEAT_W-1:0]            out_seat_warnings,
  // Configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [vwcc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [vwcc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  vwcc_pkg::cfg_t         cfg;
  vwcc_pkg::tick_in_t     tick_r;
  vwcc_pkg::chime_state_t state_r;
  vwcc_pkg::chime_state_t state_nxt;
  logic                   tick_valid_r;
  logic                   tick_valid_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   in_xfer;
  logic                   tick_adv;

  vwcc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  vwcc_tick_logic #(
    .SEAT_COUNT (SEAT_COUNT)
  ) u_tick_logic (
    .cfg  (cfg),
    .tick (tick_r),
    .cur  (state_r),
    .nxt  (state_nxt)
  );

  // The held tick moves on whenever the result register is empty or its
  // current result is being transferred out in the same cycle.
  assign tick_adv = tick_valid_r && !(out_valid_r && out_stall);
  assign in_stall = tick_valid_r && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    tick_valid_nxt = tick_valid_r;
    if (in_xfer) begin
      tick_valid_nxt = 1'b1;
    end else if (tick_adv) begin
      tick_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (tick_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= vwcc_pkg::CHIME_STATE_RST;
    end else begin
      tick_valid_r <= tick_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (tick_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tick_r.ignition_on          <= in_ignition_on;
      tick_r.door_ajar            <= in_door_ajar;
      tick_r.park_brake_on        <= in_park_brake_on;
      tick_r.vehicle_speed        <= in_vehicle_speed;
      tick_r.seat_occupied        <= in_seat_occupied;
      tick_r.belt_flags           <= in_belt_flags;
      tick_r.remote_alarm_request <= in_remote_alarm_request;
    end
  end

  // The result fields are the updated state itself, so the state register
  // doubles as the result payload register.
  assign out_valid         = out_valid_r;
  assign out_buzzer_on     = state_r.buzzer_level;
  assign out_door_warning  = state_r.door_warn;
  assign out_brake_warning = state_r.brake_warn;
  assign out_belt_warning  = state_r.belt_warn;
  assign out_seat_warnings = state_r.seat_warn;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for vehicle_warning_chime_controller_unit.
// Holds a scoreboard with its own chime predictor and drives random and directed
// control ticks under random idling. Depends on vwcc_pkg and the RTL only.
module tb_top;

  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int N_PHASES         = 8;
  localparam int TICKS_PER_PHASE  = 125;

  typedef struct packed {
    logic                        buzzer_on;
    logic                        door_warning;
    logic                        brake_warning;
    logic                        belt_warning;
    logic [vwcc_pkg::SEAT_W-1:0] seat_warnings;
  } chime_result_t;

  class chime_scoreboard;
    vwcc_pkg::cfg_t              lim;
    chime_result_t               expected_chimes[$];
    int                          failures;
    bit                          door_w;
    bit                          brake_w;
    bit                          belt_w;
    logic [vwcc_pkg::SEAT_W-1:0] seat_w;
    logic [7:0]                  blink_cnt;
    bit                          remote_on;
    logic [7:0]                  remote_cnt;
    bit                          buzz;

    function new();
      lim.door_speed_limit   = vwcc_pkg::DOOR_SPEED_LIMIT_RST;
      lim.brake_speed_limit  = vwcc_pkg::BRAKE_SPEED_LIMIT_RST;
      lim.belt_speed_limit   = vwcc_pkg::BELT_SPEED_LIMIT_RST;
      lim.blink_on_limit     = vwcc_pkg::BLINK_ON_LIMIT_RST;
      lim.blink_wrap         = vwcc_pkg::BLINK_WRAP_RST;
      lim.remote_alarm_ticks = vwcc_pkg::REMOTE_ALARM_TICKS_RST;
      failures   = 0;
      door_w     = 0;
      brake_w    = 0;
      belt_w     = 0;
      seat_w     = '0;
      blink_cnt  = '0;
      remote_on  = 0;
      remote_cnt = '0;
      buzz       = 0;
    endfunction

    function void set_limit(vwcc_pkg::cfg_idx_t idx, logic [vwcc_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        vwcc_pkg::REG_DOOR_SPEED_LIMIT:
          lim.door_speed_limit   = v[vwcc_pkg::LIMIT_W-1:0];
        vwcc_pkg::REG_BRAKE_SPEED_LIMIT:
          lim.brake_speed_limit  = v[vwcc_pkg::LIMIT_W-1:0];
        vwcc_pkg::REG_BELT_SPEED_LIMIT:
          lim.belt_speed_limit   = v[vwcc_pkg::LIMIT_W-1:0];
        vwcc_pkg::REG_BLINK_ON_LIMIT:
          lim.blink_on_limit     = v[vwcc_pkg::COUNT_W-1:0];
        vwcc_pkg::REG_BLINK_WRAP:
          lim.blink_wrap         = v[vwcc_pkg::COUNT_W-1:0];
        vwcc_pkg::REG_REMOTE_ALARM_TICKS:
          lim.remote_alarm_ticks = v[vwcc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Past the wrap point the counter only runs on, so the buzzer keeps its level.
    function void blink_step();
      blink_cnt = blink_cnt + 8'd1;
      if (blink_cnt < lim.blink_on_limit) begin
        buzz = 1;
      end else if (blink_cnt <= lim.blink_wrap) begin
        buzz = 0;
        if (blink_cnt == lim.blink_wrap) blink_cnt = '0;
      end
    endfunction

    function void note_tick(vwcc_pkg::tick_in_t t);
      int spd;
      int dlim;
      logic [vwcc_pkg::SEAT_W-1:0] seat_mask;
      chime_result_t r;
      spd = int'($signed(t.vehicle_speed));
      dlim = lim.door_speed_limit;
      seat_mask = vwcc_pkg::SEAT_W'((1 << vwcc_pkg::SEAT_COUNT_DEF) - 1);
      if (t.ignition_on) begin
        door_w  = t.door_ajar && (spd >= dlim || spd <= -dlim);
        brake_w = t.park_brake_on && (spd >= int'(lim.brake_speed_limit));
        seat_w  = t.seat_occupied & t.belt_flags & seat_mask;
        belt_w  = |seat_w;
      end else begin
        door_w  = 0;
        brake_w = 0;
      end
      if (t.remote_alarm_request) remote_on = 1;
      if (door_w || brake_w) begin
        blink_step();
      end else if (belt_w) begin
        if (spd > int'(lim.belt_speed_limit)) blink_step();
        else buzz = 0;
      end else if (remote_on) begin
        buzz = 1;
        remote_cnt = remote_cnt + 8'd1;
        if (remote_cnt > lim.remote_alarm_ticks) begin
          buzz       = 0;
          remote_on  = 0;
          remote_cnt = '0;
        end
      end else begin
        buzz      = 0;
        blink_cnt = '0;
      end
      r.buzzer_on     = buzz;
      r.door_warning  = door_w;
      r.brake_warning = brake_w;
      r.belt_warning  = belt_w;
      r.seat_warnings = seat_w;
      expected_chimes.push_back(r);
    endfunction

    function void report(string field, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_chime(chime_result_t act);
      chime_result_t exp_r;
      if (expected_chimes.size() == 0) begin
        failures++;
        $display("%0t: result with nothing expected, actual %0h", $time, act);
        return;
      end
      exp_r = expected_chimes.pop_front();
      report("buzzer_on", exp_r.buzzer_on, act.buzzer_on);
      report("door_warning", exp_r.door_warning, act.door_warning);
      report("brake_warning", exp_r.brake_warning, act.brake_warning);
      report("belt_warning", exp_r.belt_warning, act.belt_warning);
      report("seat_warnings", exp_r.seat_warnings, act.seat_warnings);
    endfunction

    function int pending();
      return expected_chimes.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  vwcc_pkg::tick_in_t              drv;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_buzzer_on;
  logic                            out_door_warning;
  logic                            out_brake_warning;
  logic                            out_belt_warning;
  logic [vwcc_pkg::SEAT_W-1:0]     out_seat_warnings;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [vwcc_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [vwcc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  chime_scoreboard sb;
  bit              long_hold_req;
  bit              quiet_tail;

  vehicle_warning_chime_controller_unit dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_ignition_on          (drv.ignition_on),
    .in_door_ajar            (drv.door_ajar),
    .in_park_brake_on        (drv.park_brake_on),
    .in_vehicle_speed        (drv.vehicle_speed),
    .in_seat_occupied        (drv.seat_occupied),
    .in_belt_flags           (drv.belt_flags),
    .in_remote_alarm_request (drv.remote_alarm_request),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_buzzer_on           (out_buzzer_on),
    .out_door_warning        (out_door_warning),
    .out_brake_warning       (out_brake_warning),
    .out_belt_warning        (out_belt_warning),
    .out_seat_warnings       (out_seat_warnings),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_addr                (cfg_addr),
    .cfg_wdata               (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("vehicle_warning_chime_controller_unit test failed");
    $finish;
  end

  // Both sides are sampled before any of this edge's updates land.
  always @(posedge clk) begin : transfer_monitor
    chime_result_t act;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tick(drv);
      if (out_valid && !out_stall) begin
        act.buzzer_on     = out_buzzer_on;
        act.door_warning  = out_door_warning;
        act.brake_warning = out_brake_warning;
        act.belt_warning  = out_belt_warning;
        act.seat_warnings = out_seat_warnings;
        sb.check_chime(act);
      end
    end
  end

  initial begin : result_stall_gen
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
      end else if (quiet_tail) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  function automatic vwcc_pkg::tick_in_t make_tick(bit ign, bit door, bit brake, int speed,
                                                   logic [7:0] seats, logic [7:0] belts,
                                                   bit req);
    vwcc_pkg::tick_in_t t;
    t.ignition_on          = ign;
    t.door_ajar            = door;
    t.park_brake_on        = brake;
    t.vehicle_speed        = 16'(speed);
    t.seat_occupied        = seats;
    t.belt_flags           = belts;
    t.remote_alarm_request = req;
    return t;
  endfunction

  // Speeds cluster around the current limits so the comparisons flip often.
  function automatic logic [vwcc_pkg::SPEED_W-1:0] pick_speed();
    int base;
    case ($urandom_range(0, 3))
      0: return vwcc_pkg::SPEED_W'($urandom);
      1: base = sb.lim.door_speed_limit;
      2: base = $urandom_range(0, 1) ? int'(sb.lim.brake_speed_limit)
                                     : int'(sb.lim.belt_speed_limit);
      default: return vwcc_pkg::SPEED_W'(int'($urandom_range(0, 800)) - 400);
    endcase
    base = base + int'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 1)) base = -base;
    return vwcc_pkg::SPEED_W'(base);
  endfunction

  // Mostly small changes to the previous tick, as a real vehicle would produce.
  function automatic vwcc_pkg::tick_in_t next_tick(vwcc_pkg::tick_in_t prev);
    vwcc_pkg::tick_in_t t;
    t = prev;
    if ($urandom_range(0, 3) == 0) begin
      t = make_tick($urandom_range(0, 4) != 0, $urandom_range(0, 1), $urandom_range(0, 1),
                    int'(pick_speed()), 8'($urandom),
                    $urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom),
                    $urandom_range(0, 7) == 0);
    end else begin
      case ($urandom_range(0, 6))
        0: t.ignition_on = ~t.ignition_on;
        1: t.door_ajar = ~t.door_ajar;
        2: t.park_brake_on = ~t.park_brake_on;
        3: t.vehicle_speed = pick_speed();
        4: t.seat_occupied = 8'($urandom);
        5: t.belt_flags = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
        default: t.remote_alarm_request = ~t.remote_alarm_request;
      endcase
    end
    return t;
  endfunction

  function automatic vwcc_pkg::cfg_t limits_for_phase(int ph);
    vwcc_pkg::cfg_t c;
    if (ph == 1) begin
      c = '{door_speed_limit: '0, brake_speed_limit: '0, belt_speed_limit: '0,
            blink_on_limit: 8'd1, blink_wrap: 8'd1, remote_alarm_ticks: 8'd0};
    end else if (ph == 2) begin
      c = '{door_speed_limit: '1, brake_speed_limit: '1, belt_speed_limit: '1,
            blink_on_limit: 8'd255, blink_wrap: 8'd255, remote_alarm_ticks: 8'd254};
    end else begin
      c.door_speed_limit  = $urandom_range(0, 4) == 0 ? 15'($urandom)
                                                      : 15'($urandom_range(0, 600));
      c.brake_speed_limit = $urandom_range(0, 4) == 0 ? 15'($urandom)
                                                      : 15'($urandom_range(0, 600));
      c.belt_speed_limit  = $urandom_range(0, 4) == 0 ? 15'($urandom)
                                                      : 15'($urandom_range(0, 600));
      c.blink_on_limit    = $urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
                                                      : 8'($urandom_range(1, 40));
      c.blink_wrap        = $urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
                                                      : 8'($urandom_range(1, 60));
      c.remote_alarm_ticks = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 254))
                                                       : 8'($urandom_range(0, 20));
    end
    return c;
  endfunction

  task automatic send_tick(vwcc_pkg::tick_in_t t);
    in_valid <= 1'b1;
    drv      <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic write_limits(vwcc_pkg::cfg_t c);
    vwcc_pkg::cfg_idx_t              idx;
    logic [vwcc_pkg::CFG_DATA_W-1:0] v;
    for (int i = int'(vwcc_pkg::REG_DOOR_SPEED_LIMIT);
         i <= int'(vwcc_pkg::REG_REMOTE_ALARM_TICKS); i++) begin
      idx = vwcc_pkg::cfg_idx_t'(i);
      case (idx)
        vwcc_pkg::REG_DOOR_SPEED_LIMIT:   v = c.door_speed_limit;
        vwcc_pkg::REG_BRAKE_SPEED_LIMIT:  v = c.brake_speed_limit;
        vwcc_pkg::REG_BELT_SPEED_LIMIT:   v = c.belt_speed_limit;
        vwcc_pkg::REG_BLINK_ON_LIMIT:     v = vwcc_pkg::CFG_DATA_W'(c.blink_on_limit);
        vwcc_pkg::REG_BLINK_WRAP:         v = vwcc_pkg::CFG_DATA_W'(c.blink_wrap);
        vwcc_pkg::REG_REMOTE_ALARM_TICKS: v = vwcc_pkg::CFG_DATA_W'(c.remote_alarm_ticks);
        default:                          v = '0;
      endcase
      cfg_valid <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= v;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_limit(idx, v);
    end
    cfg_valid <= 1'b0;
  endtask

  // Waits until every expected result has come, then lets the pipeline empty.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    vwcc_pkg::tick_in_t directed[$];
    vwcc_pkg::tick_in_t t;
    sb            = new();
    long_hold_req = 1'b0;
    quiet_tail    = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    drv           = '0;
    cfg_valid     = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Door and brake limits at the reset values, both signs, and speed extremes.
    directed.push_back(make_tick(0, 0, 0, 0, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 0, 100, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 0, -100, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 0, 99, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 0, -99, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 1, 300, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 1, 299, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 1, -32768, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 1, 32767, 8'h00, 8'h00, 0));
    // Seatbelt above and at its speed limit, then disjoint and corner seats.
    directed.push_back(make_tick(1, 0, 0, 301, 8'hFF, 8'hFF, 0));
    directed.push_back(make_tick(1, 0, 0, 300, 8'hFF, 8'hFF, 0));
    directed.push_back(make_tick(1, 0, 0, 0, 8'hAA, 8'h55, 0));
    directed.push_back(make_tick(1, 0, 0, 500, 8'h81, 8'h81, 0));
    // Ignition off clears door and brake but the seat warnings hold.
    directed.push_back(make_tick(0, 1, 1, 32767, 8'h00, 8'h00, 0));
    // A remote request under a door warning latches and runs once warnings clear.
    directed.push_back(make_tick(1, 1, 0, 200, 8'h00, 8'h00, 1));
    directed.push_back(make_tick(1, 0, 0, 0, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 0, 0, 8'h00, 8'h00, 0));
    directed.push_back(make_tick(0, 0, 0, 0, 8'hFF, 8'hFF, 0));
    foreach (directed[i]) send_tick(directed[i]);
    t = directed[directed.size() - 1];

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        settle();
        write_limits(limits_for_phase(ph));
      end
      // With a zero door limit an open door warns even at standstill.
      if (ph == 1) send_tick(make_tick(1, 1, 0, 0, 8'h00, 8'h00, 0));
      if (ph == 3) long_hold_req = 1'b1;
      if (ph == N_PHASES - 1) quiet_tail = 1'b1;
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        t = next_tick(t);
        send_tick(t);
      end
    end
    in_valid <= 1'b0;
    settle();

    if (sb.failures == 0) begin
      $display("vehicle_warning_chime_controller_unit test passed");
    end else begin
      $display("vehicle_warning_chime_controller_unit test failed");
    end
    $finish;
  end
endmodule

FILE: files.f
design/vwcc_pkg.sv
design/vwcc_cfg_regs.sv
design/vwcc_tick_logic.sv
design/vehicle_warning_chime_controller_unit.sv
sim/tb_top.sv
